// ----- rtl/core/fbc_pkg.sv -----
// fbc_pkg: shared constants and types of the frustum box cull block
// used by every module under rtl/core; depends on nothing
`default_nettype none

package fbc_pkg;

    // default sizes handed down from the top level
    localparam int PLANE_COUNT_DEF = 6;
    localparam int COORD_BITS_DEF  = 16;

    // packed plane register: a, b, c in Q1.14 then d, 16 bits each
    localparam int PLANE_W   = 64;
    localparam int COEF_W    = 16;
    localparam int D_SHIFT   = 14;

    // config index wide enough for the largest plane count of 8
    localparam int CFG_IDX_W = 3;

    // result transfer carries one drop bit padded to a byte
    localparam int OUT_DATA_W = 8;

    // register stages: vertex select, products, plane sum, drop
    localparam int PIPE_STAGES = 4;

    // per-stage load enables from the pipeline control
    typedef struct packed {
        logic s0;
        logic s1;
        logic s2;
        logic s3;
    } t_pipe_en;

endpackage : fbc_pkg

`default_nettype wire

// ----- rtl/core/fbc_plane_regs.sv -----
// fbc_plane_regs: holds the packed frustum planes written by the config port
// depends on fbc_pkg
`default_nettype none

module fbc_plane_regs
    import fbc_pkg::*;
#(
    parameter int PLANE_COUNT = PLANE_COUNT_DEF
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]                 i_cfg_index,
    input  wire logic [PLANE_W-1:0]                   i_cfg_data,
    output logic      [PLANE_COUNT-1:0][PLANE_W-1:0]  o_planes
);

    logic [PLANE_COUNT-1:0][PLANE_W-1:0] r_planes;

    // one register per plane, writes beyond the plane count fall through
    for (genvar gi = 0; gi < PLANE_COUNT; gi++) begin : g_plane
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_planes[gi] <= '0;
            end else if (i_cfg_we && (i_cfg_index == CFG_IDX_W'(gi))) begin
                r_planes[gi] <= i_cfg_data;
            end
        end
    end

    assign o_planes = r_planes;

endmodule : fbc_plane_regs

`default_nettype wire

// ----- rtl/core/fbc_pipe_ctrl.sv -----
// fbc_pipe_ctrl: valid and ready chain of the cull pipeline, carries tlast
// depends on fbc_pkg
`default_nettype none

module fbc_pipe_ctrl
    import fbc_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_s_tvalid,
    input  wire logic i_s_tlast,
    output logic      o_s_tready,
    output t_pipe_en  o_en,
    output logic      o_m_tvalid,
    output logic      o_m_tlast,
    input  wire logic i_m_tready
);

    logic [PIPE_STAGES-1:0] r_valid;
    logic [PIPE_STAGES-1:0] n_valid;
    logic [PIPE_STAGES-1:0] r_last;
    logic [PIPE_STAGES-1:0] w_rdy;

    // a stage loads when it is empty or its content moves on
    always_comb begin
        w_rdy[PIPE_STAGES-1] = !r_valid[PIPE_STAGES-1] || i_m_tready;
        for (int k = PIPE_STAGES-2; k >= 0; k--) begin
            w_rdy[k] = !r_valid[k] || w_rdy[k+1];
        end
    end

    // next valid bits
    always_comb begin
        n_valid = r_valid;
        if (w_rdy[0]) begin
            n_valid[0] = i_s_tvalid;
        end
        for (int k = 1; k < PIPE_STAGES; k++) begin
            if (w_rdy[k]) begin
                n_valid[k] = r_valid[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // tlast rides alongside the data
    always_ff @(posedge i_clk) begin
        if (w_rdy[0]) begin
            r_last[0] <= i_s_tlast;
        end
        for (int k = 1; k < PIPE_STAGES; k++) begin
            if (w_rdy[k]) begin
                r_last[k] <= r_last[k-1];
            end
        end
    end

    assign o_s_tready = w_rdy[0];
    assign o_en.s0    = w_rdy[0];
    assign o_en.s1    = w_rdy[1];
    assign o_en.s2    = w_rdy[2];
    assign o_en.s3    = w_rdy[3];
    assign o_m_tvalid = r_valid[PIPE_STAGES-1];
    assign o_m_tlast  = r_last[PIPE_STAGES-1];

    // input is held off only when every stage is occupied
    a_full_when_blocked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_tready |-> (&r_valid))
        else $error("input blocked while a stage is empty");

    // an accepted transfer lands in the first stage
    a_accept_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rst_n && i_s_tvalid && o_s_tready) |=> r_valid[0])
        else $error("accepted box missing from first stage");

    // with the sink ready the output follows the stage before it
    a_out_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rst_n && i_m_tready) |=> (o_m_tvalid == $past(r_valid[PIPE_STAGES-2])))
        else $error("output stage did not advance");

endmodule : fbc_pipe_ctrl

`default_nettype wire

// ----- rtl/core/fbc_plane_test.sv -----
// fbc_plane_test: positive-vertex test of a box against one plane, three stages
// depends on fbc_pkg; enables come from fbc_pipe_ctrl
`default_nettype none

module fbc_plane_test
    import fbc_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  wire logic                        i_clk,
    input  wire t_pipe_en                    i_en,
    input  wire logic [PLANE_W-1:0]          i_plane,
    input  wire logic [2:0][COORD_BITS-1:0]  i_min,
    input  wire logic [2:0][COORD_BITS-1:0]  i_max,
    output logic                             o_reject
);

    localparam int PROD_W = COEF_W + COORD_BITS;
    // exact sum of three products and the scaled offset
    localparam int SUM_W  = (COORD_BITS > 14) ? COORD_BITS + 18 : 32;
    localparam int DSC_W  = COEF_W + D_SHIFT;

    logic [2:0][COEF_W-1:0]     w_coef;
    logic [COEF_W-1:0]          w_d;
    logic [2:0][COORD_BITS-1:0] r_pv;
    logic signed [PROD_W-1:0]   r_prod [3];
    logic signed [SUM_W-1:0]    w_sum;
    logic signed [SUM_W-1:0]    w_dterm;
    logic                       r_reject;

    assign w_coef[0] = i_plane[COEF_W-1:0];
    assign w_coef[1] = i_plane[2*COEF_W-1:COEF_W];
    assign w_coef[2] = i_plane[3*COEF_W-1:2*COEF_W];
    assign w_d       = i_plane[4*COEF_W-1:3*COEF_W];

    // stage 0: positive vertex, max corner where the normal is non-negative
    always_ff @(posedge i_clk) begin
        if (i_en.s0) begin
            for (int k = 0; k < 3; k++) begin
                r_pv[k] <= w_coef[k][COEF_W-1] ? i_min[k] : i_max[k];
            end
        end
    end

    // stage 1: one signed product per axis, operands sign-extended to full width
    always_ff @(posedge i_clk) begin
        if (i_en.s1) begin
            for (int k = 0; k < 3; k++) begin
                r_prod[k] <= PROD_W'($signed(w_coef[k])) * PROD_W'($signed(r_pv[k]));
            end
        end
    end

    // stage 2: add the scaled offset, keep the sign
    assign w_dterm = SUM_W'($signed({w_d, {D_SHIFT{1'b0}}}) >>> 0);
    assign w_sum   = SUM_W'(r_prod[0]) + SUM_W'(r_prod[1]) + SUM_W'(r_prod[2]) + w_dterm;

    always_ff @(posedge i_clk) begin
        if (i_en.s2) begin
            r_reject <= w_sum[SUM_W-1];
        end
    end

    assign o_reject = r_reject;

    // the offset term spans the coefficient bits and the scale
    if (DSC_W > SUM_W) begin : g_bad_width
        $error("sum width too narrow for the offset term");
    end

endmodule : fbc_plane_test

`default_nettype wire

// ----- rtl/core/frustum_box_cull.sv -----
// frustum_box_cull: top level, drops boxes that lie wholly outside a frustum plane
// depends on fbc_pkg, fbc_plane_regs, fbc_pipe_ctrl, fbc_plane_test
//
//  channel   direction  handshake        payload
//  s_axis    in         tvalid/tready    tdata: min_x min_y min_z max_x max_y max_z;
//                                        tlast: batch_end
//  m_axis    out        tvalid/tready    tdata: drop; tlast: batch_end_out
//  cfg       in         i_cfg_we only    i_cfg_index selects plane, i_cfg_data packed plane
//
//  one box per cycle while m_axis accepts results; each result passes through
//  the vertex select, multiply, plane sum and drop registers in that order
//  each stage carries its own valid bit, so bubbles close up under a stall
//  and a full pipeline holds s_axis_tready low until m_axis takes a result
//  synchronous active-low reset clears planes and valid bits; no sweep
`default_nettype none

module frustum_box_cull
    import fbc_pkg::*;
#(
    parameter int PLANE_COUNT = PLANE_COUNT_DEF,
    parameter int COORD_BITS  = COORD_BITS_DEF
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    // config write
    input  wire logic                                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]                  i_cfg_index,
    input  wire logic [PLANE_W-1:0]                    i_cfg_data,
    // box input
    input  wire logic                                  s_axis_tvalid,
    output logic                                       s_axis_tready,
    // low to high: min_x, min_y, min_z, max_x, max_y, max_z, zero pad
    input  wire logic [((6*COORD_BITS+7)/8)*8-1:0]     s_axis_tdata,
    input  wire logic                                  s_axis_tlast,
    // cull result
    output logic                                       m_axis_tvalid,
    input  wire logic                                  m_axis_tready,
    // low to high: drop, zero pad
    output logic [OUT_DATA_W-1:0]                      m_axis_tdata,
    output logic                                       m_axis_tlast
);

    logic [PLANE_COUNT-1:0][PLANE_W-1:0] w_planes;
    logic [2:0][COORD_BITS-1:0]          w_min;
    logic [2:0][COORD_BITS-1:0]          w_max;
    logic [PLANE_COUNT-1:0]              w_reject;
    t_pipe_en                            w_en;
    logic                                r_drop;

    // unpack the box corners
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            w_min[k] = s_axis_tdata[k*COORD_BITS +: COORD_BITS];
            w_max[k] = s_axis_tdata[(k+3)*COORD_BITS +: COORD_BITS];
        end
    end

    fbc_plane_regs #(
        .PLANE_COUNT (PLANE_COUNT)
    ) u_regs (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_planes    (w_planes)
    );

    fbc_pipe_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_axis_tvalid),
        .i_s_tlast  (s_axis_tlast),
        .o_s_tready (s_axis_tready),
        .o_en       (w_en),
        .o_m_tvalid (m_axis_tvalid),
        .o_m_tlast  (m_axis_tlast),
        .i_m_tready (m_axis_tready)
    );

    // one test lane per plane
    for (genvar gp = 0; gp < PLANE_COUNT; gp++) begin : g_lane
        fbc_plane_test #(
            .COORD_BITS (COORD_BITS)
        ) u_test (
            .i_clk    (i_clk),
            .i_en     (w_en),
            .i_plane  (w_planes[gp]),
            .i_min    (w_min),
            .i_max    (w_max),
            .o_reject (w_reject[gp])
        );
    end

    // stage 3: any rejecting plane drops the box
    always_ff @(posedge i_clk) begin
        if (w_en.s3) begin
            r_drop <= |w_reject;
        end
    end

    assign m_axis_tdata = {{(OUT_DATA_W-1){1'b0}}, r_drop};

endmodule : frustum_box_cull

`default_nettype wire
